/* rtl/core/pee_pkg.sv */
// Package for the postfix expression evaluator.
// Holds symbol codes, opcode, error and state types and the front-to-back item struct.
// No dependencies.
package pee_pkg;

   // Character codes of the operators and of the digit zero
   localparam logic [7:0] SYM_ADD  = 8'd43;
   localparam logic [7:0] SYM_SUB  = 8'd45;
   localparam logic [7:0] SYM_MUL  = 8'd42;
   localparam logic [7:0] SYM_DIV  = 8'd47;
   localparam logic [7:0] SYM_ZERO = 8'd48;

   // Widths of the stream words
   localparam int SYMBOL_W   = 8;
   localparam int VALUE_W    = 32;
   localparam int ERROR_W    = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   // Decoupling queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef enum logic [2:0] {
      OP_PUSH,
      OP_ADD,
      OP_SUB,
      OP_MUL,
      OP_DIV
   } opcode_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_DIV_ZERO  = 2'd3
   } error_type;

   // Classified item handed from front to back
   typedef struct packed {
      opcode_type        op;
      logic [31:0]       operand;
      logic              last;
   } item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_R,
      ST_WT_R,
      ST_RD_L,
      ST_WT_L,
      ST_EXEC,
      ST_DIV,
      ST_PUSH,
      ST_FIN_RD,
      ST_FIN_WT,
      ST_OUT
   } state_type;

endpackage

/* rtl/core/pee_front.sv */
// Front stage of the postfix expression evaluator: accepts characters and decodes them.
// Depends on pee_pkg for symbol codes and the item struct.
module pee_front (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         in_symbol,
   input  logic               in_last,
   input  logic               in_valid,
   output logic               in_ready,
   output logic               out_valid,
   output pee_pkg::item_type  out_item,
   input  logic               out_ready
);

   logic              valid_ff, valid_in;
   pee_pkg::item_type item_ff, item_in;
   logic [8:0]        diff;

   // Decode the character into an opcode and an operand value
   always_comb begin
      diff            = {1'b0, in_symbol} - {1'b0, pee_pkg::SYM_ZERO};
      item_in.operand = {{23{diff[8]}}, diff};
      item_in.last    = in_last;
      unique case (in_symbol)
         pee_pkg::SYM_ADD: item_in.op = pee_pkg::OP_ADD;
         pee_pkg::SYM_SUB: item_in.op = pee_pkg::OP_SUB;
         pee_pkg::SYM_MUL: item_in.op = pee_pkg::OP_MUL;
         pee_pkg::SYM_DIV: item_in.op = pee_pkg::OP_DIV;
         default:          item_in.op = pee_pkg::OP_PUSH;
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // Hold the decoded word until the queue takes it
   always_comb begin
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

/* rtl/core/pee_queue.sv */
// Short queue of decoded items between the front and the back of the evaluator.
// Depends on pee_pkg for the item struct and the queue depth.
module pee_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  pee_pkg::item_type  push_item,
   output logic               push_ready,
   output logic               pop_valid,
   output pee_pkg::item_type  pop_item,
   input  logic               pop_ready
);

   pee_pkg::item_type                entry_ff [pee_pkg::QUEUE_DEPTH];
   logic [pee_pkg::QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [pee_pkg::QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [pee_pkg::QUEUE_AW:0]       fill_ff, fill_in;
   logic                             do_push, do_pop;

   assign push_ready = (fill_ff != (pee_pkg::QUEUE_AW + 1)'(pee_pkg::QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* rtl/core/pee_div.sv */
// Iterative signed divider for the evaluator, one quotient bit per cycle, truncating.
// Depends on no package; started by the back stage with a nonzero divisor.
module pee_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [32:0] trial;
   logic [32:0] diff;

   // One restoring step per cycle on magnitudes
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      trial   = {rem_ff, quo_ff[31]};
      diff    = trial - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[31] ? (~dividend + 32'd1) : dividend;
         dvs_in  = divisor[31]  ? (~divisor + 32'd1)  : divisor;
         neg_in  = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         rem_in  = diff[32] ? trial[31:0] : diff[31:0];
         quo_in  = {quo_ff[30:0], ~diff[32]};
         step_in = step_ff + 1'b1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   // Restore the sign of the quotient
   assign done     = done_ff;
   assign quotient = neg_ff ? (~quo_ff + 32'd1) : quo_ff;

endmodule

/* rtl/core/pee_back.sv */
// Back stage of the evaluator: operand stack memory, arithmetic sequencer, result register.
// Depends on pee_pkg and pee_div.
module pee_back #(
   parameter int STACK_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  pee_pkg::item_type  item,
   output logic               item_ready,
   output logic               rsp_valid,
   output logic [31:0]        rsp_value,
   output logic [1:0]         rsp_error,
   input  logic               rsp_ready
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   pee_pkg::state_type state_ff, state_in;
   pee_pkg::item_type  cur_ff, cur_in;
   pee_pkg::error_type err_ff, err_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [CW-1:0]      cnt_dec;
   logic [31:0]        rgt_ff, rgt_in;
   logic [31:0]        lft_ff, lft_in;
   logic [31:0]        res_ff, res_in;
   logic [63:0]        prod;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_value_ff, rsp_value_in;
   pee_pkg::error_type rsp_error_ff, rsp_error_in;
   logic               out_load;
   logic               stack_empty;
   logic               stack_full;
   logic               mem_we;
   logic [31:0]        rd_data_ff;
   logic               div_start;
   logic               div_done;
   logic [31:0]        div_quotient;
   logic [31:0]        stack_mem [STACK_DEPTH];

   assign cnt_dec     = cnt_ff - 1'b1;
   assign stack_empty = (cnt_ff == '0);
   assign stack_full  = (cnt_ff == CW'(STACK_DEPTH));
   assign prod        = lft_ff * rgt_ff;
   assign out_load    = (state_ff == pee_pkg::ST_OUT) && (!rsp_valid_ff || rsp_ready);
   assign item_ready  = (state_ff == pee_pkg::ST_IDLE);

   // Stack memory: write at the count, read below it
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[cnt_ff[AW-1:0]] <= res_ff;
      end
      rd_data_ff <= stack_mem[cnt_dec[AW-1:0]];
   end

   pee_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (lft_ff),
      .divisor  (rgt_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Sequence pops, operation, push and final pop
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      err_in       = err_ff;
      cnt_in       = cnt_ff;
      rgt_in       = rgt_ff;
      lft_in       = lft_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_error_in = rsp_error_ff;
      mem_we       = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         pee_pkg::ST_IDLE: begin
            if (item_valid) begin
               cur_in = item;
               res_in = item.operand;
               state_in = (item.op == pee_pkg::OP_PUSH) ? pee_pkg::ST_PUSH : pee_pkg::ST_RD_R;
            end
         end
         pee_pkg::ST_RD_R: begin
            if (stack_empty) begin
               rgt_in = '0;
               if (err_ff == pee_pkg::ERR_NONE) err_in = pee_pkg::ERR_UNDERFLOW;
               state_in = pee_pkg::ST_RD_L;
            end else begin
               cnt_in = cnt_dec;
               state_in = pee_pkg::ST_WT_R;
            end
         end
         pee_pkg::ST_WT_R: begin
            rgt_in = rd_data_ff;
            state_in = pee_pkg::ST_RD_L;
         end
         pee_pkg::ST_RD_L: begin
            if (stack_empty) begin
               lft_in = '0;
               if (err_ff == pee_pkg::ERR_NONE) err_in = pee_pkg::ERR_UNDERFLOW;
               state_in = pee_pkg::ST_EXEC;
            end else begin
               cnt_in = cnt_dec;
               state_in = pee_pkg::ST_WT_L;
            end
         end
         pee_pkg::ST_WT_L: begin
            lft_in = rd_data_ff;
            state_in = pee_pkg::ST_EXEC;
         end
         pee_pkg::ST_EXEC: begin
            state_in = pee_pkg::ST_PUSH;
            case (cur_ff.op)
               pee_pkg::OP_ADD: res_in = lft_ff + rgt_ff;
               pee_pkg::OP_SUB: res_in = lft_ff - rgt_ff;
               pee_pkg::OP_MUL: res_in = prod[31:0];
               default: begin
                  if (rgt_ff == '0) begin
                     res_in = '0;
                     if (err_ff == pee_pkg::ERR_NONE) err_in = pee_pkg::ERR_DIV_ZERO;
                  end else begin
                     div_start = 1'b1;
                     state_in = pee_pkg::ST_DIV;
                  end
               end
            endcase
         end
         pee_pkg::ST_DIV: begin
            if (div_done) begin
               res_in = div_quotient;
               state_in = pee_pkg::ST_PUSH;
            end
         end
         pee_pkg::ST_PUSH: begin
            if (stack_full) begin
               if (err_ff == pee_pkg::ERR_NONE) err_in = pee_pkg::ERR_OVERFLOW;
            end else begin
               mem_we = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end
            state_in = cur_ff.last ? pee_pkg::ST_FIN_RD : pee_pkg::ST_IDLE;
         end
         pee_pkg::ST_FIN_RD: begin
            if (stack_empty) begin
               res_in = '0;
               if (err_ff == pee_pkg::ERR_NONE) err_in = pee_pkg::ERR_UNDERFLOW;
               state_in = pee_pkg::ST_OUT;
            end else begin
               state_in = pee_pkg::ST_FIN_WT;
            end
         end
         pee_pkg::ST_FIN_WT: begin
            res_in = rd_data_ff;
            state_in = pee_pkg::ST_OUT;
         end
         pee_pkg::ST_OUT: begin
            if (out_load) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_error_in = err_ff;
               cnt_in = '0;
               err_in = pee_pkg::ERR_NONE;
               state_in = pee_pkg::ST_IDLE;
            end
         end
         default: state_in = pee_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pee_pkg::ST_IDLE;
         err_ff       <= pee_pkg::ERR_NONE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         err_ff       <= err_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      rgt_ff       <= rgt_in;
      lft_ff       <= lft_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_error = rsp_error_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (rgt_ff != '0))
      else $error("divider started with zero divisor");

   a_clear_after_out: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (cnt_ff == '0) && (err_ff == pee_pkg::ERR_NONE))
      else $error("stack or error not cleared after result");

   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff != pee_pkg::ERR_NONE) && !out_load |=> (err_ff == $past(err_ff)))
      else $error("recorded error changed");
`endif

endmodule

/* rtl/core/postfix_expression_evaluator.sv */
// Postfix expression evaluator. In the back stage an operand is pushed, while + - * and /
// pop two operands and push the result, / after waiting on the iterative divider.
// The item marked last adds a final pop and result load, plus any wait for the consumer.
// The front register and a 4-entry queue take items ahead while the back stage works.
// Synchronous active-high reset clears control state, stack count and error at once;
// the stack memory is not cleared, entries at or above the count are never read.
module postfix_expression_evaluator #(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] value, [33:32] error, [39:34] zero
);

   logic              f_valid;
   pee_pkg::item_type f_item;
   logic              f_ready;
   logic              q_valid;
   pee_pkg::item_type q_item;
   logic              q_ready;
   logic [31:0]       value;
   logic [1:0]        error;

   pee_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_symbol (req_tdata),
      .in_last   (req_tlast),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (f_valid),
      .out_item  (f_item),
      .out_ready (f_ready)
   );

   pee_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_item  (f_item),
      .push_ready (f_ready),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop_ready  (q_ready)
   );

   pee_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item       (q_item),
      .item_ready (q_ready),
      .rsp_valid  (rsp_tvalid),
      .rsp_value  (value),
      .rsp_error  (error),
      .rsp_ready  (rsp_tready)
   );

   // Pack the result word
   assign rsp_tdata = {6'b0, error, value};

endmodule

/* bench/postfix_result_checker.sv */
// Checker for the postfix expression evaluator: watches the symbol and result streams,
// predicts each result on its own operand stack and compares it field by field.
// Depends on pee_pkg for symbol codes and error codes.
module postfix_result_checker #(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,     // [7:0] symbol
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,     // [31:0] value, [33:32] error, [39:34] zero
   output int          fail_count,
   output int          results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0]        value;
      pee_pkg::error_type code;
   } result_word_type;

   logic [31:0]        stack_mem [STACK_DEPTH];
   int                 depth;
   pee_pkg::error_type status;
   result_word_type    owed_q [$];
   int                 fails;

   // Keep only the first error of an expression
   task automatic note_fault(input pee_pkg::error_type code);
      if (status == pee_pkg::ERR_NONE) status = code;
   endtask

   // Drop the push on a full stack
   task automatic push_value(input logic [31:0] v);
      if (depth >= STACK_DEPTH) begin
         note_fault(pee_pkg::ERR_OVERFLOW);
      end else begin
         stack_mem[depth] = v;
         depth++;
      end
   endtask

   // An empty stack yields zero
   task automatic pop_value(output logic [31:0] v);
      if (depth == 0) begin
         note_fault(pee_pkg::ERR_UNDERFLOW);
         v = '0;
      end else begin
         depth--;
         v = stack_mem[depth];
      end
   endtask

   always @(posedge clock) begin
      logic [31:0]     lhs, rhs, res;
      result_word_type want, made;
      if (reset) begin
         depth = 0;
         status = pee_pkg::ERR_NONE;
         owed_q.delete();
         fails = 0;
      end else begin
         // Compare a result word with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            if (owed_q.size() == 0) begin
               $display("%0t: unexpected result word, expected none, actual %h",
                        $time, rsp_tdata);
               fails++;
            end else begin
               want = owed_q.pop_front();
               if (rsp_tdata[31:0] !== want.value) begin
                  $display("%0t: value mismatch, expected %h, actual %h",
                           $time, want.value, rsp_tdata[31:0]);
                  fails++;
               end
               if (rsp_tdata[33:32] !== want.code) begin
                  $display("%0t: error code mismatch, expected %0d, actual %0d",
                           $time, want.code, rsp_tdata[33:32]);
                  fails++;
               end
               if (rsp_tdata[39:34] !== 6'd0) begin
                  $display("%0t: padding mismatch, expected 0, actual %h",
                           $time, rsp_tdata[39:34]);
                  fails++;
               end
            end
         end

         // Advance the operand stack with each accepted symbol word
         if (req_tvalid && req_tready) begin
            if (req_tdata inside {pee_pkg::SYM_ADD, pee_pkg::SYM_SUB,
                                  pee_pkg::SYM_MUL, pee_pkg::SYM_DIV}) begin
               pop_value(rhs);
               pop_value(lhs);
               case (req_tdata)
                  pee_pkg::SYM_ADD: res = lhs + rhs;
                  pee_pkg::SYM_SUB: res = lhs - rhs;
                  pee_pkg::SYM_MUL: res = lhs * rhs;
                  default: begin
                     // Quotient truncates toward zero; the most negative over -1 wraps
                     if (rhs == '0) begin
                        note_fault(pee_pkg::ERR_DIV_ZERO);
                        res = '0;
                     end else if (lhs == 32'h8000_0000 && rhs == 32'hFFFF_FFFF) begin
                        res = lhs;
                     end else begin
                        res = $signed(lhs) / $signed(rhs);
                     end
                  end
               endcase
               push_value(res);
            end else begin
               push_value({24'd0, req_tdata} - {24'd0, pee_pkg::SYM_ZERO});
            end

            // Pop the top on the final symbol and clear for the next expression
            if (req_tlast) begin
               pop_value(res);
               made.value = res;
               made.code = status;
               owed_q.push_back(made);
               depth = 0;
               status = pee_pkg::ERR_NONE;
            end
         end
      end
      fail_count <= fails;
      results_owed <= owed_q.size();
   end

endmodule

/* bench/testbench.sv */
// Top of the postfix expression evaluator bench: clock, reset, symbol stimulus,
// result back-pressure and the verdict. Depends on pee_pkg, the evaluator and
// postfix_result_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int RANDOM_SYMBOLS = 420;

   typedef struct {
      logic [7:0] sym;
      logic       last;
   } stream_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [7:0] symbol
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [31:0] value, [33:32] error, [39:34] zero
   int          fail_count;
   int          results_owed;

   stream_item_type symbol_stream [$];
   logic [7:0]      op_codes [4] = '{pee_pkg::SYM_ADD, pee_pkg::SYM_SUB,
                                     pee_pkg::SYM_MUL, pee_pkg::SYM_DIV};

   postfix_expression_evaluator #(
      .STACK_DEPTH(DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   postfix_result_checker #(
      .STACK_DEPTH(DEPTH)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [7:0] digit(input int d);
      return pee_pkg::SYM_ZERO + 8'(d);
   endfunction

   // Mostly decimal digits, sometimes any non-operator character
   function automatic logic [7:0] pick_operand();
      logic [7:0] s;
      if ($urandom_range(0, 9) < 7) return digit($urandom_range(0, 9));
      s = 8'($urandom_range(0, 255));
      while (s inside {pee_pkg::SYM_ADD, pee_pkg::SYM_SUB,
                       pee_pkg::SYM_MUL, pee_pkg::SYM_DIV}) begin
         s = 8'($urandom_range(0, 255));
      end
      return s;
   endfunction

   task automatic queue_symbol(input logic [7:0] sym, input logic last);
      stream_item_type it;
      it.sym = sym;
      it.last = last;
      symbol_stream.push_back(it);
   endtask

   // Symbol stimulus and verdict
   initial begin
      int directed_n, sent, gap, burst, ops_left, level, pick;
      stream_item_type it;

      // Empty stack under an operator, then the extremes of the symbol byte
      queue_symbol(pee_pkg::SYM_ADD, 1'b1);
      queue_symbol(8'hFF, 1'b1);
      queue_symbol(8'h00, 1'b1);
      // Every operator; the quotient -6 / 4 truncates to -1
      queue_symbol(digit(3), 1'b0);
      queue_symbol(digit(9), 1'b0);
      queue_symbol(pee_pkg::SYM_SUB, 1'b0);
      queue_symbol(digit(4), 1'b0);
      queue_symbol(pee_pkg::SYM_DIV, 1'b0);
      queue_symbol(digit(5), 1'b0);
      queue_symbol(pee_pkg::SYM_MUL, 1'b0);
      queue_symbol(digit(2), 1'b0);
      queue_symbol(pee_pkg::SYM_ADD, 1'b1);
      // Divide by zero, then an underflow that must not replace the first error
      queue_symbol(digit(7), 1'b0);
      queue_symbol(digit(0), 1'b0);
      queue_symbol(pee_pkg::SYM_DIV, 1'b0);
      queue_symbol(pee_pkg::SYM_ADD, 1'b1);
      // Build the most negative value as 128^4 * 8, then divide it by 0 - 1
      queue_symbol(8'hB0, 1'b0);
      repeat (3) begin
         queue_symbol(8'hB0, 1'b0);
         queue_symbol(pee_pkg::SYM_MUL, 1'b0);
      end
      queue_symbol(digit(8), 1'b0);
      queue_symbol(pee_pkg::SYM_MUL, 1'b0);
      queue_symbol(digit(0), 1'b0);
      queue_symbol(digit(1), 1'b0);
      queue_symbol(pee_pkg::SYM_SUB, 1'b0);
      queue_symbol(pee_pkg::SYM_DIV, 1'b1);
      directed_n = symbol_stream.size();

      // Random part: mostly well-formed expressions, some deep pushes and noise
      while (symbol_stream.size() < directed_n + RANDOM_SYMBOLS) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            ops_left = $urandom_range(0, 7);
            level = 0;
            while (ops_left > 0 || level != 1) begin
               if (level < 2 || (ops_left > 0 && level < 12 && $urandom_range(0, 1) == 0)) begin
                  queue_symbol(pick_operand(), 1'b0);
                  level++;
               end else begin
                  queue_symbol(op_codes[$urandom_range(0, 3)], 1'b0);
                  level--;
                  if (ops_left > 0) ops_left--;
               end
            end
            symbol_stream[$].last = 1'b1;
         end else if (pick < 85) begin
            // Push up to and past a full stack
            repeat ($urandom_range(DEPTH - 1, DEPTH + 4)) queue_symbol(pick_operand(), 1'b0);
            if ($urandom_range(0, 1) == 1) queue_symbol(op_codes[$urandom_range(0, 3)], 1'b0);
            symbol_stream[$].last = 1'b1;
         end else begin
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 2) == 0) begin
                  queue_symbol(op_codes[$urandom_range(0, 3)], $urandom_range(0, 3) == 0);
               end else begin
                  queue_symbol(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
               end
            end
         end
      end
      symbol_stream[$].last = 1'b1;

      // Hold reset, then send the stream in bursts
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      sent = 0;
      while (sent < symbol_stream.size()) begin
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
         while (burst > 0 && sent < symbol_stream.size()) begin
            it = symbol_stream[sent];
            req_tvalid <= 1'b1;
            req_tdata <= it.sym;
            req_tlast <= it.last;
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            sent++;
            burst--;
         end
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      // Drain the outstanding results, then let trailing work settle
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0 && results_owed == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Result back-pressure: a random start, one long hold-off, then mixed stretches
   initial begin
      int mode, span;
      wait (!reset);
      @(posedge clock);
      repeat ($urandom_range(100, 300)) begin
         rsp_tready <= 1'($urandom_range(0, 1));
         @(posedge clock);
      end
      rsp_tready <= 1'b0;
      repeat (400) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(1, 40);
         case (mode)
            0: begin
               rsp_tready <= 1'b1;
               repeat (span) @(posedge clock);
            end
            1: begin
               repeat (span) begin
                  rsp_tready <= 1'($urandom_range(0, 1));
                  @(posedge clock);
               end
            end
            default: begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 12)) @(posedge clock);
            end
         endcase
      end
   end

   // Give up on a hung run
   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
